>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/dsaa_pkg.sv
`default_nettype none

package dsaa_pkg;

    // Field widths
    localparam int ADC_W     = 8;
    localparam int DENS_W    = 11;
    localparam int SUM_W     = 19;
    localparam int MAG_W     = 18;
    localparam int CNT_W     = 8;
    localparam int THR_W     = 10;
    localparam int LEVEL_W   = 2;
    localparam int QSTEP_W   = 5;

    // floor(392*adc/100) = (adc * RECIP_MUL) >> RECIP_SHIFT, exact for 8-bit adc
    localparam int RECIP_MUL   = 513814;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = 28;
    localparam logic [DENS_W-1:0] DENSITY_OFFSET = 11'd20;
    localparam logic [ADC_W-1:0]  ADC_NEG_MAX    = 8'd5;
    localparam logic [9:0]        DENSITY_CAP    = 10'd999;

    // Alarm codes
    localparam logic [LEVEL_W-1:0] ALARM_GREEN  = 2'd0;
    localparam logic [LEVEL_W-1:0] ALARM_YELLOW = 2'd1;
    localparam logic [LEVEL_W-1:0] ALARM_RED    = 2'd2;

    // Register map
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_IDX_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 10'd500;

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic             end_early;
    } t_in_item;

    typedef struct packed {
        logic signed [DENS_W-1:0] dust_level;
        logic [LEVEL_W-1:0]       alarm_level;
        logic                     buzzer_on;
    } t_out_item;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [MAG_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> rtl/dsaa_stream_if.sv
`default_nettype none

interface dsaa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/dsaa_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module dsaa_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  dsaa_pkg::t_div_req i_req,
    output dsaa_pkg::t_div_rsp o_rsp
);
    import dsaa_pkg::*;

    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [MAG_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]   r_div;
    logic [QSTEP_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [CNT_W:0]     w_trial;
    logic [CNT_W:0]     w_diff;
    logic               w_fit;

    // Shift the next dividend bit into the remainder and try to subtract
    always_comb begin
        w_trial = {r_rem, r_quo[MAG_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
        n_rem   = w_fit ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
        n_quo   = {r_quo[MAG_W-2:0], w_fit};
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= QSTEP_W'(MAG_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath shift registers
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

>>> rtl/dust_sample_average_alarm.sv
// Flow: a sample that does not close the window is taken and gives no result. A closing
// sample passes a registered start that loads the divider, the bit-serial quotient (one
// bit per cycle), the result register and the output register.
// Throughput: one sample per cycle inside a window; after the closing sample no sample is
// taken until its result enters the output register, which waits while a previous result
// is stalled at the output. Reset (synchronous, active low): sum and count clear, threshold returns to 500.
`default_nettype none
`include "assert_macros.svh"

module dust_sample_average_alarm #(
    parameter int SAMPLES = 80
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    dsaa_stream_if.sink                  i_in,
    dsaa_stream_if.source                o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [dsaa_pkg::APB_AW-1:0]   paddr,
    input  wire [dsaa_pkg::APB_DW-1:0]   pwdata,
    output logic [dsaa_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import dsaa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } t_state;

    t_state                   r_state;
    logic [THR_W-1:0]         r_threshold;
    logic signed [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_dividend;
    logic [CNT_W-1:0]         r_divisor;
    logic                     r_start;
    t_out_item                r_res, n_res;
    t_out_item                r_out;
    logic                     r_out_valid;

    logic                     w_accept;
    logic                     w_close;
    logic                     w_out_free;
    logic [PROD_W-1:0]        w_prod;
    logic signed [DENS_W-1:0] w_density;
    logic signed [SUM_W-1:0]  w_neg_sum;
    logic [9:0]               w_capped;
    logic signed [DENS_W-1:0] w_avg;
    logic signed [DENS_W:0]   w_avg_x;
    logic signed [DENS_W:0]   w_thr_x;
    logic signed [DENS_W:0]   w_half_x;
    t_div_req                 w_div_req;
    t_div_rsp                 w_div_rsp;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {{(APB_DW-THR_W){1'b0}}, r_threshold};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDX_THRESHOLD) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    // Sample density: floor(3.92*adc) - 20, rounded toward zero for negative values
    always_comb begin
        w_prod    = PROD_W'(i_in.data.adc_sample) * PROD_W'(RECIP_MUL);
        w_density = DENS_W'(w_prod[PROD_W-1:RECIP_SHIFT]) - DENSITY_OFFSET
                    + DENS_W'((i_in.data.adc_sample != '0)
                              && (i_in.data.adc_sample <= ADC_NEG_MAX));
        n_sum     = r_sum + SUM_W'(w_density);
        n_cnt     = r_cnt + 1'b1;
        w_close   = i_in.data.end_early || (n_cnt == '0)
                    || ({24'd0, n_cnt} >= 32'(SAMPLES));
        w_neg_sum = -n_sum;
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Sign, cap and class the divider quotient
    always_comb begin
        w_capped = (w_div_rsp.quotient > MAG_W'(DENSITY_CAP)) ? DENSITY_CAP
                   : w_div_rsp.quotient[9:0];
        w_avg    = r_neg ? -$signed({1'b0, w_capped}) : $signed({1'b0, w_capped});
        w_avg_x  = {w_avg[DENS_W-1], w_avg};
        w_thr_x  = $signed({2'b00, r_threshold});
        w_half_x = $signed({3'b000, r_threshold[THR_W-1:1]});
        n_res.dust_level = w_avg;
        if (w_avg_x >= w_thr_x) begin
            n_res.alarm_level = ALARM_RED;
        end else if (w_avg_x >= w_half_x) begin
            n_res.alarm_level = ALARM_YELLOW;
        end else begin
            n_res.alarm_level = ALARM_GREEN;
        end
        n_res.buzzer_on = (n_res.alarm_level == ALARM_RED);
    end

    assign w_div_req.start    = r_start;
    assign w_div_req.dividend = r_dividend;
    assign w_div_req.divisor  = r_divisor;

    dsaa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Sequencer: accumulate, divide at window close, hand result to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (w_close) begin
                            r_sum      <= '0;
                            r_cnt      <= '0;
                            r_neg      <= n_sum[SUM_W-1];
                            r_dividend <= n_sum[SUM_W-1] ? w_neg_sum[MAG_W-1:0]
                                                         : n_sum[MAG_W-1:0];
                            r_divisor  <= n_cnt;
                            r_start    <= 1'b1;
                            r_state    <= ST_DIV;
                        end else begin
                            r_sum <= n_sum;
                            r_cnt <= n_cnt;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_div_rsp.done) begin
                        r_res   <= n_res;
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Checks
    `ASSERT_IMPL(a_buzzer_red, i_clk, i_rst_n, o_out.valid, o_out.data.buzzer_on == (o_out.data.alarm_level == ALARM_RED), "buzzer disagrees with alarm level")
    `ASSERT_IMPL(a_cap, i_clk, i_rst_n, o_out.valid, $signed(o_out.data.dust_level) <= $signed(11'sd999), "dust level above cap")
    `ASSERT_IMPL(a_no_take_busy, i_clk, i_rst_n, r_state == ST_DIV, !i_in.ready, "sample taken during divide")
    `ASSERT_IMPL(a_done_in_div, i_clk, i_rst_n, w_div_rsp.done, r_state == ST_DIV, "divider done outside divide state")

endmodule

`default_nettype wire

>>> tb/sv/dust_sample_average_alarm_test.sv
module dust_sample_average_alarm_test;
    import dsaa_pkg::*;

    localparam int WINDOW_LEN    = 80;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 30;
    localparam logic [APB_AW-1:0] THRESHOLD_ADDR = {REG_IDX_THRESHOLD, 2'b00};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic     in_valid  = 1'b0;
    t_in_item in_data   = '0;
    logic     out_ready = 1'b0;

    dsaa_stream_if #(.T(t_in_item))  in_if ();
    dsaa_stream_if #(.T(t_out_item)) out_if ();

    assign in_if.valid  = in_valid;
    assign in_if.data   = in_data;
    assign out_if.ready = out_ready;

    dust_sample_average_alarm #(
        .SAMPLES(WINDOW_LEN)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Pending samples, expected window readings and the predictor's own state
    t_in_item        sample_q[$];
    t_out_item       expected_readings[$];
    int              win_sum     = 0;
    int              win_count   = 0;
    logic [THR_W-1:0] thr_shadow = THRESHOLD_RESET;

    int   queued_cnt   = 0;
    int   accepted_cnt = 0;
    int   fail_cnt     = 0;
    int   cycle_cnt    = 0;
    int   in_gap       = 0;
    int   out_gap      = 0;
    logic in_fire      = 1'b0;
    logic no_idle      = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Density of one sample, truncated toward zero
    function automatic int adc_to_density(input logic [ADC_W-1:0] adc);
        int v;
        v = int'(adc) * 392 - 2000;
        return v / 100;
    endfunction

    // Smallest sample whose density reaches the target, saturating at full scale
    function automatic int first_adc_reaching(input int target);
        for (int a = 0; a < 256; a++) begin
            if (adc_to_density(a[ADC_W-1:0]) >= target) return a;
        end
        return 255;
    endfunction

    // Sum one sample into the window; on close, queue the expected reading
    function automatic void accumulate_sample(input t_in_item s);
        int        avg;
        t_out_item r;
        win_sum   += adc_to_density(s.adc_sample);
        win_count += 1;
        if (s.end_early || win_count >= WINDOW_LEN) begin
            avg = win_sum / win_count;
            if (avg > int'(DENSITY_CAP)) avg = int'(DENSITY_CAP);
            win_sum   = 0;
            win_count = 0;
            r.dust_level = avg[DENS_W-1:0];
            if (avg >= int'(thr_shadow)) begin
                r.alarm_level = ALARM_RED;
            end else if (avg >= int'(thr_shadow >> 1)) begin
                r.alarm_level = ALARM_YELLOW;
            end else begin
                r.alarm_level = ALARM_GREEN;
            end
            r.buzzer_on = (r.alarm_level == ALARM_RED);
            expected_readings.push_back(r);
        end
    endfunction

    task automatic add_sample(input int adc, input logic early);
        t_in_item s;
        s.adc_sample = adc[ADC_W-1:0];
        s.end_early  = early;
        sample_q.push_back(s);
        queued_cnt++;
    endtask

    // Pick a sample according to the window's bias
    function automatic int pick_adc(input int bias);
        int a;
        case (bias)
            1: a = $urandom_range(0, 8);
            2: a = $urandom_range(240, 255);
            3: a = first_adc_reaching(int'(thr_shadow)) + $urandom_range(0, 4) - 2;
            4: a = first_adc_reaching(int'(thr_shadow >> 1)) + $urandom_range(0, 4) - 2;
            default: a = $urandom_range(0, 255);
        endcase
        if (a < 0) a = 0;
        if (a > 255) a = 255;
        return a;
    endfunction

    // Queue a well-formed window: early end on the last sample, and at random when it fills up
    task automatic add_window(input int len);
        int   bias;
        logic early;
        bias = $urandom_range(0, 6);
        for (int i = 0; i < len; i++) begin
            early = (i == len - 1) && (len < WINDOW_LEN || $urandom_range(0, 1) == 1);
            add_sample(pick_adc(bias), early);
        end
    endtask

    // Queue a stretch of samples with scattered early-end flags
    task automatic add_noise(input int len);
        for (int i = 0; i < len; i++) begin
            add_sample(pick_adc(0), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read_check(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        got = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            fail_cnt++;
            $error("alarm_threshold: expected %0d, actual %0d", want, got);
        end
    endtask

    // Hold until every queued sample is taken and every reading has come out
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || expected_readings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_threshold(input int thr);
        logic [APB_DW-1:0] word;
        word = $urandom;
        word[THR_W-1:0] = thr[THR_W-1:0];
        reg_write(THRESHOLD_ADDR, word);
        thr_shadow = thr[THR_W-1:0];
        reg_read_check(THRESHOLD_ADDR, {{(APB_DW-THR_W){1'b0}}, thr_shadow});
    endtask

    // Drive samples: hold an offered transaction until taken, idle in bursts
    always @(negedge i_clk) begin : drive_samples
        logic     v;
        t_in_item nxt;
        v   = in_valid;
        nxt = in_data;
        if (!in_valid || in_fire) begin
            if (in_gap > 0) begin
                v = 1'b0;
                in_gap--;
            end else if (sample_q.size() > 0) begin
                nxt = sample_q.pop_front();
                v   = 1'b1;
                if (!no_idle && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
            end else begin
                v = 1'b0;
            end
        end
        in_valid <= v;
        in_data  <= nxt;
    end

    // Stall the result side in bursts
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_ready <= 1'b0;
            out_gap--;
        end else begin
            out_ready <= 1'b1;
            if (!no_idle && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 14);
        end
    end

    // Predict on each accepted sample, compare each accepted reading
    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            in_fire <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                accumulate_sample(in_if.data);
                accepted_cnt++;
            end
            if (out_if.valid && out_if.ready) begin
                got = out_if.data;
                if (expected_readings.size() == 0) begin
                    fail_cnt++;
                    $error("unexpected reading: dust_level %0d, alarm_level %0d, buzzer_on %0d",
                           got.dust_level, got.alarm_level, got.buzzer_on);
                end else begin
                    want = expected_readings.pop_front();
                    if (got.dust_level !== want.dust_level) begin
                        fail_cnt++;
                        $error("dust_level: expected %0d, actual %0d",
                               want.dust_level, got.dust_level);
                    end
                    if (got.alarm_level !== want.alarm_level) begin
                        fail_cnt++;
                        $error("alarm_level: expected %0d, actual %0d",
                               want.alarm_level, got.alarm_level);
                    end
                    if (got.buzzer_on !== want.buzzer_on) begin
                        fail_cnt++;
                        $error("buzzer_on: expected %0d, actual %0d",
                               want.buzzer_on, got.buzzer_on);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("dust_sample_average_alarm_test: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int thr;
        int start_cnt;
        int r;
        int a;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Threshold comes out of reset at its default
        reg_read_check(THRESHOLD_ADDR, {{(APB_DW-THR_W){1'b0}}, THRESHOLD_RESET});

        // Single-sample windows: extremes, zero crossing, and both class edges at default
        add_sample(0, 1'b1);
        add_sample(255, 1'b1);
        add_sample(5, 1'b1);
        add_sample(6, 1'b1);
        add_sample(68, 1'b1);
        add_sample(69, 1'b1);
        add_sample(132, 1'b1);
        add_sample(133, 1'b1);
        add_sample(128, 1'b1);
        // Negative averages, two with truncation toward zero
        add_sample(0, 1'b0);
        add_sample(5, 1'b1);
        add_sample(0, 1'b0);
        add_sample(6, 1'b1);
        add_sample(0, 1'b0);
        add_sample(0, 1'b0);
        add_sample(1, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: thr = 0;
                1: thr = 1000;
                2: thr = 1023;
                3: thr = 1;
                4: thr = adc_to_density($urandom_range(6, 255));
                5: thr = 2 * adc_to_density($urandom_range(6, 130));
                6: thr = 2 * adc_to_density($urandom_range(6, 130)) + 1;
                7: thr = $urandom_range(0, 1000);
                default: thr = THRESHOLD_RESET;
            endcase
            set_threshold(thr);
            if (p == PHASE_COUNT - 1) no_idle = 1'b1;

            // Straddle both class edges of this threshold
            a = first_adc_reaching(int'(thr_shadow));
            add_sample(a, 1'b1);
            if (a > 0) add_sample(a - 1, 1'b1);
            a = first_adc_reaching(int'(thr_shadow >> 1));
            add_sample(a, 1'b1);
            if (a > 0) add_sample(a - 1, 1'b1);

            // Mostly well-formed windows, some noise in between
            start_cnt = queued_cnt;
            while (queued_cnt - start_cnt < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    add_noise($urandom_range(5, 20));
                end else if (r < 70) begin
                    add_window($urandom_range(1, 6));
                end else if (r < 92) begin
                    add_window($urandom_range(7, WINDOW_LEN - 1));
                end else begin
                    add_window(WINDOW_LEN);
                end
            end
            wait_drained();
        end

        if (fail_cnt == 0) begin
            $display("dust_sample_average_alarm_test: PASS");
        end else begin
            $display("dust_sample_average_alarm_test: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/dsaa_pkg.sv
rtl/dsaa_stream_if.sv
rtl/dsaa_div.sv
rtl/dust_sample_average_alarm.sv
tb/sv/dust_sample_average_alarm_test.sv
